>>> rtl/dsw_pkg.sv
package dsw_pkg;

    // Field widths fixed by the interface.
    localparam int VALUE_W = 27;
    localparam int DIGIT_W = 4;
    localparam int CNT_W   = 4;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 8;

    // Driver register map and segment constants.
    localparam logic [ADDR_W-1:0] SCAN_LIMIT_ADDR = 4'hB;
    localparam logic [DATA_W-1:0] POINT_BIT       = 8'h80;
    localparam logic [CNT_W-1:0]  SHOWN_NONE      = 4'hF;

    // Reciprocal of ten: floor(x * RECIP / 2^RECIP_SHIFT) == x / 10 for x < 2^32.
    localparam int               RECIP_W     = 32;
    localparam int               RECIP_SHIFT = 35;
    localparam logic [RECIP_W-1:0] RECIP     = 32'hCCCC_CCCD;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_POINT_POSITION = 1'b0,
        CFG_MIN_DIGITS     = 1'b1
    } cfg_index_t;

    // Seven-segment code of one decimal digit.
    function automatic logic [DATA_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
        logic [DATA_W-1:0] code;
        case (digit)
            4'd0:    code = 8'h7E;
            4'd1:    code = 8'h30;
            4'd2:    code = 8'h6D;
            4'd3:    code = 8'h79;
            4'd4:    code = 8'h33;
            4'd5:    code = 8'h5B;
            4'd6:    code = 8'h5F;
            4'd7:    code = 8'h70;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h7B;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/dsw_div10.sv
module dsw_div10
    import dsw_pkg::*;
(
    input  logic               aclk,
    input  logic               load,
    input  logic [VALUE_W-1:0] x,
    output logic [VALUE_W-1:0] q,
    output logic [DIGIT_W-1:0] r
);

    localparam int PROD_W = VALUE_W + RECIP_W;

    logic [PROD_W-1:0]  prod_reg;
    logic [VALUE_W-1:0] x_reg;
    logic [VALUE_W-1:0] q_times_ten;
    logic [VALUE_W-1:0] rem_full;

    // Register the reciprocal product together with the dividend.
    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg    <= x;
            prod_reg <= PROD_W'(x) * PROD_W'(RECIP);
        end
    end

    // Quotient is a slice of the product; remainder follows by shift-add.
    assign q           = VALUE_W'(prod_reg >> RECIP_SHIFT);
    assign q_times_ten = (q << 3) + (q << 1);
    assign rem_full    = x_reg - q_times_ten;
    assign r           = rem_full[DIGIT_W-1:0];

endmodule

>>> rtl/decimal_seven_segment_writer.sv
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_count_value
// m_        out        m_valid / m_ready   m_reg_addr, m_reg_data, m_last_write
// cfg_      in         cfg_wr_en           cfg_index, cfg_wdata
//
// Each value is split into digits through a single shared divide-by-ten unit (one
// digit per cycle) and then sent out as register writes, one write at a time.
// s_ready is high only while the sequencer is idle; a stalled m_ready holds the write.
// Reset is synchronous and active low; it restores the configuration defaults and
// marks the scan limit as never written.
module decimal_seven_segment_writer
    import dsw_pkg::*;
#(
    parameter int MAX_DIGITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VALUE_W-1:0] s_count_value,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [ADDR_W-1:0]  m_reg_addr,
    output logic [DATA_W-1:0]  m_reg_data,
    output logic               m_last_write,

    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_index,
    input  logic [CNT_W-1:0]   cfg_wdata
);

    localparam int             IDX_W   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_DIGITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PLAN,
        S_SCAN,
        S_DIGIT
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   needed_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   shown_reg;
    logic [CNT_W-1:0]   point_pos_reg;
    logic [CNT_W-1:0]   min_digits_reg;
    logic [DIGIT_W-1:0] digit_reg [MAX_DIGITS];
    logic               m_valid_reg;
    logic [ADDR_W-1:0]  m_addr_reg;
    logic [DATA_W-1:0]  m_data_reg;
    logic               m_last_reg;

    logic               in_xfer;
    logic               out_xfer;
    logic               div_load;
    logic [VALUE_W-1:0] div_x;
    logic [VALUE_W-1:0] div_q;
    logic [DIGIT_W-1:0] div_r;
    logic [CNT_W-1:0]   floor_digits;
    logic [CNT_W-1:0]   n_plan;
    logic [CNT_W-1:0]   n_cur;
    logic [CNT_W-1:0]   tgt_pos;
    logic [CNT_W-1:0]   tgt_off;
    logic [IDX_W-1:0]   tgt_idx;
    logic [DATA_W-1:0]  digit_data;
    logic               digit_last;

    assign s_ready      = (state_reg == S_IDLE);
    assign in_xfer      = s_valid && s_ready;
    assign out_xfer     = m_valid_reg && m_ready;
    assign m_valid      = m_valid_reg;
    assign m_reg_addr   = m_addr_reg;
    assign m_reg_data   = m_data_reg;
    assign m_last_write = m_last_reg;

    // Shared divide-by-ten unit, fed the new value first and then its own quotient.
    assign div_load = in_xfer || (state_reg == S_DIV);
    assign div_x    = (state_reg == S_DIV) ? div_q : s_count_value;

    dsw_div10 u_div10 (
        .aclk (aclk),
        .load (div_load),
        .x    (div_x),
        .q    (div_q),
        .r    (div_r)
    );

    // Digit count: decimal length raised to the clamped minimum.
    always_comb begin
        if (min_digits_reg == '0) begin
            floor_digits = CNT_W'(1);
        end else if (min_digits_reg > MAX_CNT) begin
            floor_digits = MAX_CNT;
        end else begin
            floor_digits = min_digits_reg;
        end
        n_plan = (needed_reg > floor_digits) ? needed_reg : floor_digits;
        n_cur  = (state_reg == S_PLAN) ? n_plan : n_reg;
    end

    // Next digit write: position 1 after planning or the scan write, else the following one.
    always_comb begin
        tgt_pos    = (state_reg == S_DIGIT) ? (pos_reg + CNT_W'(1)) : CNT_W'(1);
        tgt_off    = tgt_pos - CNT_W'(1);
        tgt_idx    = tgt_off[IDX_W-1:0];
        digit_data = seg_code(digit_reg[tgt_idx]);
        if (tgt_pos == point_pos_reg) begin
            digit_data = digit_data | POINT_BIT;
        end
        digit_last = (tgt_pos == n_cur);
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_pos_reg  <= CNT_W'(3);
            min_digits_reg <= CNT_W'(3);
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_POINT_POSITION: point_pos_reg  <= cfg_wdata;
                CFG_MIN_DIGITS:     min_digits_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    // Sequencer with the registered output write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            shown_reg   <= SHOWN_NONE;
            idx_reg     <= '0;
            needed_reg  <= CNT_W'(1);
            n_reg       <= CNT_W'(1);
            pos_reg     <= CNT_W'(1);
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        idx_reg    <= '0;
                        needed_reg <= CNT_W'(1);
                        state_reg  <= S_DIV;
                    end
                end
                S_DIV: begin
                    // A nonzero quotient means the value reaches the next digit.
                    digit_reg[idx_reg] <= div_r;
                    if ((div_q != '0) && (idx_reg != IDX_LAST)) begin
                        needed_reg <= CNT_W'(idx_reg) + CNT_W'(2);
                    end
                    if (idx_reg == IDX_LAST) begin
                        state_reg <= S_PLAN;
                    end else begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_PLAN: begin
                    n_reg       <= n_plan;
                    m_valid_reg <= 1'b1;
                    if (n_plan != shown_reg) begin
                        shown_reg  <= n_plan;
                        m_addr_reg <= SCAN_LIMIT_ADDR;
                        m_data_reg <= DATA_W'(n_plan - CNT_W'(1));
                        m_last_reg <= 1'b0;
                        state_reg  <= S_SCAN;
                    end else begin
                        pos_reg    <= tgt_pos;
                        m_addr_reg <= tgt_pos;
                        m_data_reg <= digit_data;
                        m_last_reg <= digit_last;
                        state_reg  <= S_DIGIT;
                    end
                end
                S_SCAN: begin
                    if (out_xfer) begin
                        pos_reg    <= tgt_pos;
                        m_addr_reg <= tgt_pos;
                        m_data_reg <= digit_data;
                        m_last_reg <= digit_last;
                        state_reg  <= S_DIGIT;
                    end
                end
                S_DIGIT: begin
                    if (out_xfer) begin
                        if (m_last_reg) begin
                            m_valid_reg <= 1'b0;
                            state_reg   <= S_IDLE;
                        end else begin
                            pos_reg    <= tgt_pos;
                            m_addr_reg <= tgt_pos;
                            m_data_reg <= digit_data;
                            m_last_reg <= digit_last;
                        end
                    end
                end
                default: begin
                    m_valid_reg <= 1'b0;
                    state_reg   <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // A new value is never taken while a write is still pending.
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input accepted while a write is pending");

    // Digit writes stay within the shown digit positions.
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_reg_addr != SCAN_LIMIT_ADDR)) |->
            ((m_reg_addr >= ADDR_W'(1)) && (m_reg_addr <= n_reg)))
        else $error("digit write outside the shown digits");

    // The marked write is the top digit position.
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_write) |-> (m_reg_addr == n_reg))
        else $error("last write not at the top digit");

    // A scan-limit write carries the stored count minus one and is never the last.
    a_scan_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_reg_addr == SCAN_LIMIT_ADDR)) |->
            ((m_reg_data == DATA_W'(n_reg - CNT_W'(1))) && (shown_reg == n_reg)
             && !m_last_write))
        else $error("scan-limit write inconsistent with the digit count");

    // After the final transfer of a value the block is ready again.
    a_return_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_write) |=> s_ready)
        else $error("block not idle after the final write");
`endif

endmodule
